// File: design/io_write_notifier_match_table_assert.svh
// Assertion macros shared by the notifier match table RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef IO_WRITE_NOTIFIER_MATCH_TABLE_ASSERT_SVH
`define IO_WRITE_NOTIFIER_MATCH_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define IWN_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("notifier match table assertion failed");

// Property checked at every clock edge, reset included.
`define IWN_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("notifier match table assertion failed");

`else

`define IWN_ASSERT(lbl, prop)
`define IWN_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// File: design/iwn_pkg.sv
`default_nettype none

package iwn_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 64;
    localparam int SIZE_W   = 4;
    localparam int VALUE_W  = 64;
    localparam int FLAGS_W  = 3;
    localparam int TARGET_W = 32;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIRE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOMATCH  = 3'd4;

    localparam int FLAG_ANY_SIZE  = 0;
    localparam int FLAG_ANY_VALUE = 1;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [SIZE_W-1:0]   size;
        logic [VALUE_W-1:0]  value;
        logic [FLAGS_W-1:0]  flags;
        logic [TARGET_W-1:0] target;
    } entry_t;

endpackage

`default_nettype wire

// File: design/iwn_req_if.sv
`default_nettype none

interface iwn_req_if;
    logic                         valid;
    logic                         ready;
    logic [iwn_pkg::CMD_W-1:0]    command;
    logic [iwn_pkg::ADDR_W-1:0]   access_addr;
    logic [iwn_pkg::SIZE_W-1:0]   access_size;
    logic [iwn_pkg::VALUE_W-1:0]  access_value;
    logic [iwn_pkg::FLAGS_W-1:0]  match_flags;
    logic [iwn_pkg::TARGET_W-1:0] target_id;

    modport source (
        output valid, command, access_addr, access_size, access_value,
               match_flags, target_id,
        input  ready
    );

    modport sink (
        input  valid, command, access_addr, access_size, access_value,
               match_flags, target_id,
        output ready
    );
endinterface

`default_nettype wire

// File: design/iwn_rsp_if.sv
`default_nettype none

interface iwn_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [iwn_pkg::STATUS_W-1:0] status;
    logic [iwn_pkg::TARGET_W-1:0] notify_target;
    logic                         last_result;

    modport source (
        output valid, status, notify_target, last_result,
        input  ready
    );

    modport sink (
        input  valid, status, notify_target, last_result,
        output ready
    );
endinterface

`default_nettype wire

// File: design/io_write_notifier_match_table.sv
// The block takes one request at a time and accepts no new one until the final result
// is loaded into the output register; the single comparator visits one table slot per
// cycle while the scan is not paused by a stalled result port.
// A fire presents one result per match, each held back until the next match or the scan end.
// Reset (rst_n, asynchronous, active low) clears all entry valid bits and the sequencer at
// once; there is no clearing pass and the block is ready as soon as reset is released.
`default_nettype none

`include "io_write_notifier_match_table_assert.svh"

module io_write_notifier_match_table (
    input  wire logic   clk,
    input  wire logic   rst_n,
    iwn_req_if.sink     req,
    iwn_rsp_if.source   rsp
);

    // Sequencer states: idle, scanning the table, presenting the final result.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [iwn_pkg::IDX_W-1:0] LAST_IDX = iwn_pkg::IDX_W'(iwn_pkg::TABLE_ENTRIES - 1);
    localparam logic [iwn_pkg::CNT_W-1:0] MAX_CNT  = iwn_pkg::CNT_W'(iwn_pkg::MAX_RESULTS);

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // The table itself: valid bits in flip-flops, entry contents in a memory.
    logic [iwn_pkg::TABLE_ENTRIES-1:0] valid_reg;
    iwn_pkg::entry_t                   mem [iwn_pkg::TABLE_ENTRIES];

    // The request being worked on.
    logic [iwn_pkg::CMD_W-1:0] req_cmd_reg;
    iwn_pkg::entry_t           req_ent_reg;

    // Read stage: slot index being issued, and the registered entry being compared.
    logic [iwn_pkg::IDX_W-1:0] scan_idx_reg;
    logic                      issue_vld_reg;
    logic [iwn_pkg::IDX_W-1:0] rd_idx_reg;
    logic                      rd_vld_reg;
    iwn_pkg::entry_t           rd_data_reg;

    // Scan results gathered slot by slot.
    logic                         found_reg;
    logic [iwn_pkg::IDX_W-1:0]    found_idx_reg;
    logic                         free_found_reg;
    logic [iwn_pkg::IDX_W-1:0]    free_idx_reg;
    logic                         pend_vld_reg;
    logic [iwn_pkg::TARGET_W-1:0] pend_target_reg;
    logic [iwn_pkg::CNT_W-1:0]    hit_cnt_reg;

    // Output register.
    logic                         out_vld_reg;
    logic [iwn_pkg::STATUS_W-1:0] out_status_reg;
    logic [iwn_pkg::TARGET_W-1:0] out_target_reg;
    logic                         out_last_reg;

    logic                         accept;
    logic                         cmp_hit;
    logic                         ent_valid;
    logic                         ent_hit;
    logic                         take;
    logic                         out_free;
    logic                         emit;
    logic                         stall;
    logic                         adv;
    logic                         scan_end;
    logic                         mem_re;
    logic                         mem_we;
    logic                         done_load;
    logic [iwn_pkg::STATUS_W-1:0] fin_status;
    logic [iwn_pkg::TARGET_W-1:0] fin_target;
    iwn_pkg::entry_t              in_ent;

    // One comparator serves every command; add and remove ask for the exact test.
    iwn_cmp u_cmp (
        .entry (rd_data_reg),
        .probe (req_ent_reg),
        .exact (req_cmd_reg != iwn_pkg::CMD_FIRE),
        .hit   (cmp_hit)
    );

    always_comb
    begin
        in_ent.addr   = req.access_addr;
        in_ent.size   = req.access_size;
        in_ent.value  = req.access_value;
        in_ent.flags  = req.match_flags;
        in_ent.target = req.target_id;

        accept    = req.valid && req.ready;
        ent_valid = valid_reg[rd_idx_reg];
        ent_hit   = ent_valid && cmp_hit;
        take      = ent_hit && (req_cmd_reg == iwn_pkg::CMD_FIRE) && (hit_cnt_reg < MAX_CNT);
        out_free  = !out_vld_reg || rsp.ready;

        // A fire match is held back until the next one turns up, so that only the
        // final match of the scan carries the last-result mark. Releasing the held
        // match needs a free output register; otherwise the scan pauses.
        emit      = (state_reg == ST_SCAN) && rd_vld_reg && (req_cmd_reg == iwn_pkg::CMD_FIRE)
                    && take && pend_vld_reg;
        stall     = emit && !out_free;
        adv       = (state_reg == ST_SCAN) && !stall;
        scan_end  = adv && rd_vld_reg && (rd_idx_reg == LAST_IDX);
        mem_re    = adv && issue_vld_reg;
        done_load = (state_reg == ST_DONE) && out_free;

        fin_target = '0;
        unique case (req_cmd_reg)
            iwn_pkg::CMD_ADD:
            begin
                // The full check comes before the duplicate check.
                if (!free_found_reg)
                    fin_status = iwn_pkg::STATUS_FULL;
                else if (found_reg)
                    fin_status = iwn_pkg::STATUS_DUP;
                else
                    fin_status = iwn_pkg::STATUS_OK;
            end
            iwn_pkg::CMD_REMOVE:
            begin
                fin_status = found_reg ? iwn_pkg::STATUS_OK : iwn_pkg::STATUS_NOTFOUND;
            end
            default:
            begin
                fin_status = pend_vld_reg ? iwn_pkg::STATUS_OK : iwn_pkg::STATUS_NOMATCH;
                fin_target = pend_vld_reg ? pend_target_reg : '0;
            end
        endcase

        mem_we = done_load && (req_cmd_reg == iwn_pkg::CMD_ADD) && free_found_reg && !found_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.command != iwn_pkg::CMD_NONE))
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_end)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req.ready = (state_reg == ST_IDLE);

    assign rsp.valid         = out_vld_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.notify_target = out_target_reg;
    assign rsp.last_result   = out_last_reg;

    // Entry memory: one write port for add, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[free_idx_reg] <= req_ent_reg;
        if (mem_re)
        begin
            rd_data_reg <= mem[scan_idx_reg];
            rd_idx_reg  <= scan_idx_reg;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_cmd_reg <= req.command;
            req_ent_reg <= in_ent;
        end
        if (adv && rd_vld_reg && take)
            pend_target_reg <= rd_data_reg.target;
        if (adv && rd_vld_reg && ent_hit && !found_reg)
            found_idx_reg <= rd_idx_reg;
        if (adv && rd_vld_reg && !ent_valid && !free_found_reg)
            free_idx_reg <= rd_idx_reg;
        if (emit && out_free)
        begin
            out_status_reg <= iwn_pkg::STATUS_OK;
            out_target_reg <= pend_target_reg;
            out_last_reg   <= 1'b0;
        end
        else if (done_load)
        begin
            out_status_reg <= fin_status;
            out_target_reg <= fin_target;
            out_last_reg   <= 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            scan_idx_reg   <= '0;
            issue_vld_reg  <= 1'b0;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            pend_vld_reg   <= 1'b0;
            hit_cnt_reg    <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                scan_idx_reg   <= '0;
                issue_vld_reg  <= (req.command != iwn_pkg::CMD_NONE);
                rd_vld_reg     <= 1'b0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                pend_vld_reg   <= 1'b0;
                hit_cnt_reg    <= '0;
            end
            else if (adv)
            begin
                // Issue side walks the slots once.
                rd_vld_reg <= issue_vld_reg;
                if (issue_vld_reg)
                begin
                    if (scan_idx_reg == LAST_IDX)
                        issue_vld_reg <= 1'b0;
                    else
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                end

                // Compare side records the lowest equal and lowest free slots, and
                // counts fire matches up to the result limit.
                if (rd_vld_reg)
                begin
                    if (ent_hit)
                        found_reg <= 1'b1;
                    if (!ent_valid)
                        free_found_reg <= 1'b1;
                    if (take)
                    begin
                        pend_vld_reg <= 1'b1;
                        hit_cnt_reg  <= hit_cnt_reg + 1'b1;
                    end
                end
            end

            if (mem_we)
                valid_reg[free_idx_reg] <= 1'b1;
            else if (done_load && (req_cmd_reg == iwn_pkg::CMD_REMOVE) && found_reg)
                valid_reg[found_idx_reg] <= 1'b0;

            if ((emit && out_free) || done_load)
                out_vld_reg <= 1'b1;
            else if (rsp.ready)
                out_vld_reg <= 1'b0;
        end
    end

    // The read pipeline is empty whenever the sequencer is not scanning.
    `IWN_ASSERT_ALWAYS(a_idle_pipe_empty, (state_reg != ST_SCAN) |-> (!rd_vld_reg && !issue_vld_reg))
    // The number of reported fire matches never passes the result limit.
    `IWN_ASSERT_ALWAYS(a_hit_cnt_limit, hit_cnt_reg <= MAX_CNT)
    // A held fire match exists only while a fire command is in hand.
    `IWN_ASSERT(a_pend_fire_only, pend_vld_reg |-> (req_cmd_reg == iwn_pkg::CMD_FIRE))
    // A paused scan keeps the entry under comparison.
    `IWN_ASSERT(a_stall_holds, (state_reg == ST_SCAN && stall) |=> $stable(rd_idx_reg))
    // The table is never written and read in the same cycle.
    `IWN_ASSERT(a_no_rw_overlap, !(mem_we && mem_re))

endmodule

`default_nettype wire

// File: design/iwn_cmp.sv
`default_nettype none

// Shared entry comparator. In exact mode the target and flags must also agree,
// which is the test used by add and remove; otherwise it is the fire match.
module iwn_cmp (
    input  wire iwn_pkg::entry_t entry,
    input  wire iwn_pkg::entry_t probe,
    input  wire logic            exact,
    output logic                 hit
);

    logic addr_eq;
    logic size_ok;
    logic value_ok;
    logic extra_ok;

    always_comb
    begin
        addr_eq  = (entry.addr == probe.addr);
        size_ok  = entry.flags[iwn_pkg::FLAG_ANY_SIZE] || (entry.size == probe.size);
        value_ok = entry.flags[iwn_pkg::FLAG_ANY_VALUE] || (entry.value == probe.value);
        extra_ok = !exact || ((entry.target == probe.target) && (entry.flags == probe.flags));
        hit      = addr_eq && size_ok && value_ok && extra_ok;
    end

endmodule

`default_nettype wire

// File: verif/io_write_notifier_match_table_test.sv
`default_nettype none

module io_write_notifier_match_table_test;

    import iwn_pkg::*;

    // No transfer on either channel for this many cycles means the block has hung.
    // The slowest correct gap is the longest sender pause followed by a scan of the whole
    // table, or the longest result stall, so this is far beyond it.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles allowed after the last expected result, enough for two full scans.
    localparam int DRAIN_CYCLES   = 2 * (TABLE_ENTRIES + 3) + 2;
    localparam int RANDOM_ITEMS   = 65;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [ADDR_W-1:0]   ADDR_ONES   = '1;
    localparam logic [VALUE_W-1:0]  VALUE_ONES  = '1;
    localparam logic [TARGET_W-1:0] TARGET_ONES = '1;
    localparam logic [ADDR_W-1:0]   FILL_ADDR   = 64'h0000_00FE_E000_1000;
    localparam logic [FLAGS_W-1:0]  FLAGS_NONE  = 3'b000;
    localparam logic [FLAGS_W-1:0]  FLAGS_ANY   = 3'b011;
    localparam logic [FLAGS_W-1:0]  FLAGS_EXIT  = 3'b100;
    localparam logic [FLAGS_W-1:0]  FLAGS_ALL   = 3'b111;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [ADDR_W-1:0]   addr;
        logic [SIZE_W-1:0]   size;
        logic [VALUE_W-1:0]  value;
        logic [FLAGS_W-1:0]  flags;
        logic [TARGET_W-1:0] target;
    } notifier_req_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [TARGET_W-1:0] notify_target;
        logic                last_result;
    } notifier_result_t;

    // A row of the directed table. Where the outcome is plain to see, the row carries
    // it and that single result is what the block has to return; otherwise the
    // table model decides.
    typedef struct {
        notifier_req_t       req;
        bit                  typed;
        logic [STATUS_W-1:0] status;
        logic [TARGET_W-1:0] notify_target;
    } directed_row_t;

    logic clk;
    logic rst_n;

    iwn_req_if req_ch ();
    iwn_rsp_if rsp_ch ();

    io_write_notifier_match_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the notifier table, advanced once per accepted request.
    bit                 model_valid [TABLE_ENTRIES];
    entry_t             model_entry [TABLE_ENTRIES];

    notifier_result_t   pending_results[$];
    directed_row_t      directed_rows[$];
    logic [ADDR_W-1:0]  addr_pool [4];

    int                 mismatch_count;
    int                 result_count;
    int                 quiet_cycles;
    bit                 req_burst;
    bit                 rsp_burst;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // An entry answers an access when the address agrees and the size and value agree
    // unless the entry's wildcard bit for that field is set.
    function automatic bit entry_hits(input int i, input logic [ADDR_W-1:0] addr,
                                      input logic [SIZE_W-1:0] size,
                                      input logic [VALUE_W-1:0] value);
        return (model_entry[i].addr == addr)
            && (model_entry[i].flags[FLAG_ANY_SIZE] || model_entry[i].size == size)
            && (model_entry[i].flags[FLAG_ANY_VALUE] || model_entry[i].value == value);
    endfunction

    // Lowest valid slot holding an entry equal to the request, or -1. Equality also
    // needs the flags, the exit-when-full bit among them, and the target to agree.
    function automatic int equal_slot(input notifier_req_t r);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (model_valid[i] && entry_hits(i, r.addr, r.size, r.value)
                && model_entry[i].target == r.target && model_entry[i].flags == r.flags)
                return i;
        end
        return -1;
    endfunction

    // Advances the shadow table by one request and queues the results it should give.
    task automatic predict_notifier_results(input notifier_req_t r, input bit typed,
                                            input logic [STATUS_W-1:0] status,
                                            input logic [TARGET_W-1:0] notify_target);
        notifier_result_t outcome[$];
        notifier_result_t one;
        int slot;
        int hit;
        slot = -1;
        if (r.cmd == CMD_ADD)
        begin
            for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                if (!model_valid[i])
                    slot = i;
            // A full table is reported before any duplicate.
            if (slot < 0)
                one = '{status: STATUS_FULL, notify_target: '0, last_result: 1'b1};
            else if (equal_slot(r) >= 0)
                one = '{status: STATUS_DUP, notify_target: '0, last_result: 1'b1};
            else
            begin
                model_valid[slot] = 1'b1;
                model_entry[slot] = '{addr: r.addr, size: r.size, value: r.value,
                                      flags: r.flags, target: r.target};
                one = '{status: STATUS_OK, notify_target: '0, last_result: 1'b1};
            end
            outcome.push_back(one);
        end
        else if (r.cmd == CMD_REMOVE)
        begin
            hit = equal_slot(r);
            if (hit < 0)
                one = '{status: STATUS_NOTFOUND, notify_target: '0, last_result: 1'b1};
            else
            begin
                model_valid[hit] = 1'b0;
                one = '{status: STATUS_OK, notify_target: '0, last_result: 1'b1};
            end
            outcome.push_back(one);
        end
        else if (r.cmd == CMD_FIRE)
        begin
            // One result per matching slot in ascending order, at most MAX_RESULTS.
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (outcome.size() < MAX_RESULTS && model_valid[i]
                    && entry_hits(i, r.addr, r.size, r.value))
                begin
                    one = '{status: STATUS_OK, notify_target: model_entry[i].target,
                            last_result: 1'b0};
                    outcome.push_back(one);
                end
            end
            if (outcome.size() == 0)
            begin
                one = '{status: STATUS_NOMATCH, notify_target: '0, last_result: 1'b1};
                outcome.push_back(one);
            end
            else
                outcome[outcome.size() - 1].last_result = 1'b1;
        end
        // The unused command leaves the table alone and gives nothing back.
        if (typed)
        begin
            outcome.delete();
            one = '{status: status, notify_target: notify_target, last_result: 1'b1};
            outcome.push_back(one);
        end
        foreach (outcome[k])
            pending_results.push_back(outcome[k]);
    endtask

    task automatic table_row(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                             input logic [SIZE_W-1:0] size,
                             input logic [VALUE_W-1:0] value,
                             input logic [FLAGS_W-1:0] flags,
                             input logic [TARGET_W-1:0] target, input bit typed,
                             input logic [STATUS_W-1:0] status,
                             input logic [TARGET_W-1:0] notify_target);
        directed_row_t row;
        row.req = '{cmd: cmd, addr: addr, size: size, value: value, flags: flags,
                    target: target};
        row.typed = typed;
        row.status = status;
        row.notify_target = notify_target;
        directed_rows.push_back(row);
    endtask

    // Random requests lean on the shadow table: most removes, and many adds and fires,
    // copy a live entry so that duplicates, removals and multiple matches occur, while
    // the rest are noise on a small pool of addresses, or anywhere at all.
    function automatic notifier_req_t random_request();
        notifier_req_t r;
        entry_t e;
        int live[$];
        int pick;
        bit copy;
        pick = $urandom_range(0, 99);
        r.addr = addr_pool[$urandom_range(0, 3)];
        if ($urandom_range(0, 7) == 0)
            r.addr = {$urandom, $urandom};
        r.size = SIZE_W'($urandom);
        r.value = {$urandom, $urandom};
        r.flags = FLAGS_W'($urandom);
        r.target = $urandom;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (model_valid[i])
                live.push_back(i);
        copy = 1'b0;
        if (pick < 5)
            r.cmd = CMD_NONE;
        else if (pick < 42)
        begin
            r.cmd = CMD_ADD;
            copy = (live.size() > 0) && ($urandom_range(0, 3) == 0);
        end
        else if (pick < 68)
        begin
            r.cmd = CMD_REMOVE;
            copy = (live.size() > 0) && ($urandom_range(0, 4) != 0);
        end
        else
        begin
            r.cmd = CMD_FIRE;
            copy = (live.size() > 0) && ($urandom_range(0, 3) != 0);
        end
        if (copy)
        begin
            e = model_entry[live[$urandom_range(0, live.size() - 1)]];
            r.addr = e.addr;
            if (!e.flags[FLAG_ANY_SIZE] || $urandom_range(0, 1) == 0)
                r.size = e.size;
            if (!e.flags[FLAG_ANY_VALUE] || $urandom_range(0, 1) == 0)
                r.value = e.value;
            if (r.cmd != CMD_FIRE)
            begin
                r.flags = e.flags;
                r.target = e.target;
            end
        end
        return r;
    endfunction

    // Presents one request after a random pause and returns at the edge where it is
    // transferred. The prediction is made there, so it follows the order of transfers.
    // Valid stays high into the next request when that one has no pause.
    task automatic send_request(input notifier_req_t r, input bit typed,
                                input logic [STATUS_W-1:0] status,
                                input logic [TARGET_W-1:0] notify_target);
        int gap;
        if ($urandom_range(0, 11) == 0)
            req_burst = !req_burst;
        gap = req_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= r.cmd;
        req_ch.access_addr  <= r.addr;
        req_ch.access_size  <= r.size;
        req_ch.access_value <= r.value;
        req_ch.match_flags  <= r.flags;
        req_ch.target_id    <= r.target;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_notifier_results(r, typed, status, notify_target);
    endtask

    // Result side: before each transfer, ready is held low for a random number of
    // cycles, with occasional stretches in which it is never dropped.
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        rsp_burst = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 11) == 0)
                rsp_burst = !rsp_burst;
            stall = rsp_burst ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
        end
    end

    // Every result transfer is checked against the oldest expectation. Values are
    // sampled at the edge, before any of this edge's assignments take effect.
    always @(posedge clk)
    begin
        notifier_result_t exp;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
                flag_mismatch($sformatf("result %0d with none expected: status %0d target %h",
                                        result_count, rsp_ch.status, rsp_ch.notify_target));
            else
            begin
                exp = pending_results.pop_front();
                if (rsp_ch.status !== exp.status)
                    flag_mismatch($sformatf("result %0d status: expected %0d, got %0d",
                                            result_count, exp.status, rsp_ch.status));
                if (rsp_ch.notify_target !== exp.notify_target)
                    flag_mismatch($sformatf("result %0d target: expected %h, got %h",
                                            result_count, exp.notify_target,
                                            rsp_ch.notify_target));
                if (rsp_ch.last_result !== exp.last_result)
                    flag_mismatch($sformatf("result %0d last: expected %0b, got %0b",
                                            result_count, exp.last_result,
                                            rsp_ch.last_result));
            end
        end
    end

    // The watchdog ends the run when neither channel has seen a transfer for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no transfer for %0d cycles, %0d results pending",
                         $time, quiet_cycles, pending_results.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        notifier_req_t r;
        int issued;

        mismatch_count = 0;
        result_count = 0;
        quiet_cycles = 0;
        req_burst = 1'b0;
        foreach (model_valid[i])
        begin
            model_valid[i] = 1'b0;
            model_entry[i] = '0;
        end
        addr_pool[0] = '0;
        addr_pool[1] = ADDR_ONES;
        addr_pool[2] = {$urandom, $urandom};
        addr_pool[3] = {$urandom, $urandom};

        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.command      <= CMD_NONE;
        req_ch.access_addr  <= '0;
        req_ch.access_size  <= '0;
        req_ch.access_value <= '0;
        req_ch.match_flags  <= '0;
        req_ch.target_id    <= '0;

        // Directed table. After reset the table is empty, so the first fire finds nothing
        // and the first remove fails. The all-ones entry then checks an exact duplicate,
        // an exact fire and a size mismatch. A wildcard entry makes an add with other
        // size and value a duplicate and a remove with other size and value a hit,
        // while a differing exit-when-full bit keeps two entries apart.
        table_row(CMD_FIRE, '0, '0, '0, FLAGS_NONE, '0, 1'b1, STATUS_NOMATCH, '0);
        table_row(CMD_REMOVE, '0, '0, '0, FLAGS_NONE, '0, 1'b1, STATUS_NOTFOUND, '0);
        table_row(CMD_ADD, ADDR_ONES, 4'hF, VALUE_ONES, FLAGS_NONE, TARGET_ONES,
                  1'b1, STATUS_OK, '0);
        table_row(CMD_ADD, ADDR_ONES, 4'hF, VALUE_ONES, FLAGS_NONE, TARGET_ONES,
                  1'b1, STATUS_DUP, '0);
        table_row(CMD_FIRE, ADDR_ONES, 4'hF, VALUE_ONES, FLAGS_NONE, '0,
                  1'b1, STATUS_OK, TARGET_ONES);
        table_row(CMD_FIRE, ADDR_ONES, 4'hE, VALUE_ONES, FLAGS_NONE, '0,
                  1'b1, STATUS_NOMATCH, '0);
        table_row(CMD_ADD, '0, 4'h0, '0, FLAGS_ANY, '0, 1'b1, STATUS_OK, '0);
        table_row(CMD_ADD, '0, 4'h5, 64'h7, FLAGS_ANY, '0, 1'b1, STATUS_DUP, '0);
        table_row(CMD_ADD, '0, 4'h1, '0, FLAGS_EXIT, 32'h5A5A_5A5A, 1'b1, STATUS_OK, '0);
        table_row(CMD_FIRE, '0, 4'h1, '0, FLAGS_NONE, '0, 1'b0, STATUS_OK, '0);
        table_row(CMD_REMOVE, '0, 4'h9, 64'h9, FLAGS_ANY, '0, 1'b1, STATUS_OK, '0);
        table_row(CMD_REMOVE, '0, 4'h1, '0, FLAGS_NONE, 32'h5A5A_5A5A,
                  1'b1, STATUS_NOTFOUND, '0);
        table_row(CMD_NONE, ADDR_ONES, 4'hF, VALUE_ONES, FLAGS_ALL, TARGET_ONES,
                  1'b0, STATUS_OK, '0);
        table_row(CMD_REMOVE, ADDR_ONES, 4'hF, VALUE_ONES, FLAGS_NONE, TARGET_ONES,
                  1'b1, STATUS_OK, '0);
        table_row(CMD_REMOVE, '0, 4'h1, '0, FLAGS_EXIT, 32'h5A5A_5A5A, 1'b1,
                  STATUS_OK, '0);
        // Fill every slot with wildcard entries at one address, so that a full table
        // can be seen, the full check beating the duplicate check, and a fire that
        // returns the largest number of results.
        for (int i = 0; i < TABLE_ENTRIES; i++)
            table_row(CMD_ADD, FILL_ADDR, SIZE_W'(i), {32'hC0DE_0000, i},
                      FLAGS_ANY | {i[0], 2'b00}, 32'h100 + i, 1'b0, STATUS_OK, '0);
        table_row(CMD_ADD, FILL_ADDR, 4'h0, '0, FLAGS_ANY, 32'h100, 1'b1, STATUS_FULL, '0);
        table_row(CMD_ADD, ADDR_ONES, 4'h2, '0, FLAGS_NONE, 32'h1, 1'b1, STATUS_FULL, '0);
        table_row(CMD_FIRE, FILL_ADDR, 4'h3, VALUE_ONES, FLAGS_NONE, '0,
                  1'b0, STATUS_OK, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_request(directed_rows[k].req, directed_rows[k].typed,
                         directed_rows[k].status, directed_rows[k].notify_target);

        // Random part; requests the block ignores do not count towards the total.
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            r = random_request();
            send_request(r, 1'b0, STATUS_OK, '0);
            if (r.cmd != CMD_NONE)
                issued++;
        end
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
